[rtl/dht_pkg.sv]
// Shared widths, codes and defaults for the double hash table engine.
package dht_pkg;

    localparam int TYPE_W   = 2;
    localparam int DATA_W   = 32;
    localparam int HASH_W   = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;
    localparam int LOAD_W   = 7;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    localparam logic [LOAD_W-1:0] LOAD_DEFAULT = 7'd75;
    localparam int                LOAD_SCALE   = 100;

    typedef logic [TYPE_W-1:0] t_req;
    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_FIND   = 2'd1;
    localparam t_req REQ_REMOVE = 2'd2;

    typedef logic [1:0] t_mark;
    localparam t_mark MARK_EMPTY   = 2'd0;
    localparam t_mark MARK_BUSY    = 2'd1;
    localparam t_mark MARK_DELETED = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_OVER_LOAD = 3'd4
    } t_status;

endpackage

[rtl/dht_if.sv]
// Request and response channel interfaces of the double hash table engine.
interface dht_req_if;
    import dht_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [DATA_W-1:0] req_key;
    logic [DATA_W-1:0] req_value;
    logic [HASH_W-1:0] probe_start;
    logic [HASH_W-1:0] probe_step;

    modport source (
        output valid, req_type, req_key, req_value, probe_start, probe_step,
        input  ready
    );
    modport sink (
        input  valid, req_type, req_key, req_value, probe_start, probe_step,
        output ready
    );
endinterface

interface dht_rsp_if;
    import dht_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   found_value;
    logic [COUNT_W-1:0]  occupied_count;
    logic [COUNT_W-1:0]  tombstone_count;

    modport source (
        output valid, status, found_value, occupied_count, tombstone_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_value, occupied_count, tombstone_count,
        output ready
    );
endinterface

[rtl/double_hash_table_engine.sv]
// Top level: open-addressing key/value table with double hashing and tombstones.
//
// Requests arrive on i_req (insert, find or remove with key, value and the two
// hashes); each one returns exactly one transaction on o_rsp carrying a status,
// the found value and the busy and deleted slot counts after the request.
// i_cfg_we/i_cfg_data write the load limit in percent (reset value 75); write
// it only while no request is in flight.
//
// One request is handled at a time. Each request probes 1 .. TABLE_DEPTH slots;
// when TABLE_DEPTH is below 1024 the hashes are first folded below it by
// repeated subtraction of TABLE_DEPTH. ready returns with response valid, so
// a new request is accepted only after the last one has been handed to the
// output register. Over-load refusals and unused request kinds skip probing.
// One slot is probed per cycle: the key, value and mark memories each have a
// single registered read port.
//
// After reset the mark memory is swept to empty, one slot per cycle, through
// all TABLE_DEPTH slots; i_req.ready stays low meanwhile. The response sits in an
// output register; the next request is accepted while it waits, but a
// finished request holds until o_rsp is free.
module double_hash_table_engine #(
    parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = dht_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = dht_pkg::DEF_VALUE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dht_pkg::LOAD_W-1:0] i_cfg_data,
    dht_req_if.sink                   i_req,
    dht_rsp_if.source                 o_rsp
);
    import dht_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int WW   = ((HASH_W > IDXW) ? HASH_W : IDXW) + 1;
    localparam int LW   = CNTW + 9;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [IDXW-1:0]       r_clr, n_clr;
    t_req                  r_type, n_type;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [WW-1:0]         r_start, n_start;
    logic [WW-1:0]         r_step, n_step;
    logic [IDXW-1:0]       r_idx, n_idx;
    logic [CNTW-1:0]       r_cnt, n_cnt;
    logic                  r_have_del, n_have_del;
    logic [IDXW-1:0]       r_del_idx, n_del_idx;
    logic [CNTW-1:0]       r_busy, n_busy;
    logic [CNTW-1:0]       r_del, n_del;
    logic [LOAD_W-1:0]     r_max_load, n_max_load;
    t_status               r_res_status, n_res_status;
    logic [VALUE_BITS-1:0] r_res_found, n_res_found;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [DATA_W-1:0]     r_out_found, n_out_found;
    logic [COUNT_W-1:0]    r_out_busy, n_out_busy;
    logic [COUNT_W-1:0]    r_out_del, n_out_del;

    // slot memories, registered read at rd_addr
    logic [KEY_BITS-1:0]   r_key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [TABLE_DEPTH];
    t_mark                 r_mark_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_key_rd;
    logic [VALUE_BITS-1:0] r_val_rd;
    t_mark                 r_mark_rd;

    logic            mk_we;
    logic [IDXW-1:0] mk_wa;
    t_mark           mk_wd;
    logic            kv_we;
    logic [IDXW-1:0] kv_wa;
    logic [IDXW-1:0] rd_addr;

    logic [IDXW:0]   nxt_sum;
    logic [IDXW-1:0] nxt_idx;
    logic            last_probe;
    logic [LW-1:0]   load_sum;
    logic [LW-1:0]   load_lhs;
    logic [LW-1:0]   load_rhs;
    logic            over_load;

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            r_key_mem[kv_wa] <= r_key;
            r_val_mem[kv_wa] <= r_val;
        end
        r_key_rd <= r_key_mem[rd_addr];
        r_val_rd <= r_val_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mark_mem[mk_wa] <= mk_wd;
        end
        r_mark_rd <= r_mark_mem[rd_addr];
    end

    // next probe slot: (idx + step) mod depth, both operands already below depth
    assign nxt_sum    = {1'b0, r_idx} + {1'b0, r_step[IDXW-1:0]};
    assign nxt_idx    = (nxt_sum >= (IDXW+1)'(TABLE_DEPTH))
                        ? IDXW'(nxt_sum - (IDXW+1)'(TABLE_DEPTH)) : IDXW'(nxt_sum);
    assign last_probe = (r_cnt == CNTW'(TABLE_DEPTH - 1));

    // floor(n*100/depth) > max  <=>  n*100 >= (max+1)*depth
    assign load_sum  = LW'(r_busy) + LW'(r_del);
    assign load_lhs  = load_sum * LW'(LOAD_SCALE);
    assign load_rhs  = (LW'(r_max_load) + LW'(1)) * LW'(TABLE_DEPTH);
    assign over_load = (load_lhs >= load_rhs);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_type       = r_type;
        n_key        = r_key;
        n_val        = r_val;
        n_start      = r_start;
        n_step       = r_step;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_have_del   = r_have_del;
        n_del_idx    = r_del_idx;
        n_busy       = r_busy;
        n_del        = r_del;
        n_max_load   = i_cfg_we ? i_cfg_data : r_max_load;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_busy   = r_out_busy;
        n_out_del    = r_out_del;
        mk_we        = 1'b0;
        mk_wa        = r_idx;
        mk_wd        = MARK_EMPTY;
        kv_we        = 1'b0;
        kv_wa        = r_idx;
        rd_addr      = r_idx;

        case (r_state)
            S_CLEAR: begin
                mk_we = 1'b1;
                mk_wa = r_clr;
                if (r_clr == IDXW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + IDXW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type  = i_req.req_type;
                    n_key   = KEY_BITS'(i_req.req_key);
                    n_val   = VALUE_BITS'(i_req.req_value);
                    n_start = WW'(i_req.probe_start);
                    n_step  = WW'(i_req.probe_step);
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                rd_addr = r_start[IDXW-1:0];
                if (r_start >= WW'(TABLE_DEPTH)) begin
                    n_start = r_start - WW'(TABLE_DEPTH);
                end else if (r_step >= WW'(TABLE_DEPTH)) begin
                    n_step = r_step - WW'(TABLE_DEPTH);
                end else if (r_type == REQ_INSERT && over_load) begin
                    n_res_status = ST_OVER_LOAD;
                    n_res_found  = '0;
                    n_state      = S_DONE;
                end else if (r_type != REQ_INSERT && r_type != REQ_FIND
                             && r_type != REQ_REMOVE) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_found  = '0;
                    n_state      = S_DONE;
                end else begin
                    n_idx      = r_start[IDXW-1:0];
                    n_cnt      = '0;
                    n_have_del = 1'b0;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                // marks/keys/values read last cycle at r_idx; fetch the next slot now
                rd_addr     = nxt_idx;
                n_idx       = nxt_idx;
                n_cnt       = r_cnt + CNTW'(1);
                n_res_found = '0;
                if (r_mark_rd == MARK_BUSY && r_key_rd == r_key) begin
                    n_state = S_DONE;
                    if (r_type == REQ_INSERT) begin
                        n_res_status = ST_DUP;
                    end else if (r_type == REQ_FIND) begin
                        n_res_status = ST_OK;
                        n_res_found  = r_val_rd;
                    end else begin
                        mk_we        = 1'b1;
                        mk_wa        = r_idx;
                        mk_wd        = MARK_DELETED;
                        n_busy       = r_busy - CNTW'(1);
                        n_del        = r_del + CNTW'(1);
                        n_res_status = ST_OK;
                    end
                end else if (r_mark_rd == MARK_EMPTY || last_probe) begin
                    n_state = S_DONE;
                    if (r_type == REQ_INSERT) begin
                        if (r_have_del || r_mark_rd == MARK_DELETED) begin
                            // reuse the first tombstone passed
                            kv_we        = 1'b1;
                            kv_wa        = r_have_del ? r_del_idx : r_idx;
                            mk_we        = 1'b1;
                            mk_wa        = kv_wa;
                            mk_wd        = MARK_BUSY;
                            n_busy       = r_busy + CNTW'(1);
                            n_del        = r_del - CNTW'(1);
                            n_res_status = ST_OK;
                        end else if (r_mark_rd == MARK_EMPTY) begin
                            kv_we        = 1'b1;
                            kv_wa        = r_idx;
                            mk_we        = 1'b1;
                            mk_wa        = r_idx;
                            mk_wd        = MARK_BUSY;
                            n_busy       = r_busy + CNTW'(1);
                            n_res_status = ST_OK;
                        end else begin
                            n_res_status = ST_NO_SLOT;
                        end
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                end else if (r_mark_rd == MARK_DELETED && !r_have_del) begin
                    n_have_del = 1'b1;
                    n_del_idx  = r_idx;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = DATA_W'(r_res_found);
                    n_out_busy   = COUNT_W'(r_busy);
                    n_out_del    = COUNT_W'(r_del);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_busy      <= '0;
            r_del       <= '0;
            r_max_load  <= LOAD_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_type       <= n_type;
            r_key        <= n_key;
            r_val        <= n_val;
            r_start      <= n_start;
            r_step       <= n_step;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_have_del   <= n_have_del;
            r_del_idx    <= n_del_idx;
            r_busy       <= n_busy;
            r_del        <= n_del;
            r_max_load   <= n_max_load;
            r_res_status <= n_res_status;
            r_res_found  <= n_res_found;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_found  <= n_out_found;
            r_out_busy   <= n_out_busy;
            r_out_del    <= n_out_del;
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.found_value     = r_out_found;
    assign o_rsp.occupied_count  = r_out_busy;
    assign o_rsp.tombstone_count = r_out_del;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNTW+1)'(r_busy) + (CNTW+1)'(r_del) <= (CNTW+1)'(TABLE_DEPTH))
        else $error("busy plus deleted slots exceed table depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> r_cnt < CNTW'(TABLE_DEPTH))
        else $error("probe sequence ran past table depth");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("response raised without a finished request");

endmodule

[bench/tb_double_hash_table_engine.sv]
// Self-checking testbench for the double hash table engine: directed and random requests.
`timescale 1ns / 100ps

module tb_double_hash_table_engine;
    import dht_pkg::*;

    localparam int   DEPTH      = DEF_TABLE_DEPTH;
    localparam int   POOL       = 64;
    localparam int   LIMIT      = 3_000_000;
    localparam t_req REQ_UNUSED = 2'd3;

    typedef struct packed {
        t_req              kind;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [HASH_W-1:0] start;
        logic [HASH_W-1:0] step;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  found_value;
        logic [COUNT_W-1:0] occupied_count;
        logic [COUNT_W-1:0] tombstone_count;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [LOAD_W-1:0] cfg_data;

    dht_req_if req_bus ();
    dht_rsp_if rsp_bus ();

    double_hash_table_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the table
    logic [DATA_W-1:0] slot_key  [DEPTH];
    logic [DATA_W-1:0] slot_value[DEPTH];
    t_mark             slot_mark [DEPTH] = '{default: MARK_EMPTY};
    int                busy_total    = 0;
    int                deleted_total = 0;
    logic [LOAD_W-1:0] load_limit    = LOAD_DEFAULT;

    t_request requests_todo[$];
    t_answer  answers_due[$];
    t_request on_bus;
    t_answer  want;

    logic [DATA_W-1:0] pool_key  [POOL];
    logic [HASH_W-1:0] pool_start[POOL];
    logic [HASH_W-1:0] pool_step [POOL];

    int errors       = 0;
    int results_seen = 0;
    int cycles       = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit quiet        = 1'b0;

    // Walks start + i*step; stops at an empty slot or the matching busy key.
    // With reuse set, an empty or exhausted walk returns the first tombstone passed.
    function automatic int probe_chain(logic [DATA_W-1:0] key, int start, int step, bit reuse);
        int first_del;
        int idx;
        first_del = -1;
        for (int i = 0; i < DEPTH; i++) begin
            idx = (start + i * step) % DEPTH;
            if (slot_mark[idx] == MARK_EMPTY)
                return (reuse && first_del >= 0) ? first_del : idx;
            if (slot_mark[idx] == MARK_DELETED && first_del < 0)
                first_del = idx;
            if (slot_mark[idx] == MARK_BUSY && slot_key[idx] == key)
                return idx;
        end
        return (reuse && first_del >= 0) ? first_del : -1;
    endfunction

    function automatic t_answer hash_table_apply(t_request rq);
        t_answer ans;
        int      slot;
        ans.status      = ST_NOT_FOUND;
        ans.found_value = '0;
        case (rq.kind)
            REQ_INSERT: begin
                if ((busy_total + deleted_total) * LOAD_SCALE / DEPTH > int'(load_limit)) begin
                    ans.status = ST_OVER_LOAD;
                end else begin
                    slot = probe_chain(rq.key, int'(rq.start), int'(rq.step), 1'b1);
                    if (slot < 0) begin
                        ans.status = ST_NO_SLOT;
                    end else if (slot_mark[slot] == MARK_BUSY) begin
                        ans.status = ST_DUP;
                    end else begin
                        if (slot_mark[slot] == MARK_DELETED)
                            deleted_total--;
                        slot_key[slot]   = rq.key;
                        slot_value[slot] = rq.value;
                        slot_mark[slot]  = MARK_BUSY;
                        busy_total++;
                        ans.status = ST_OK;
                    end
                end
            end
            REQ_FIND: begin
                slot = probe_chain(rq.key, int'(rq.start), int'(rq.step), 1'b0);
                if (slot >= 0 && slot_mark[slot] == MARK_BUSY) begin
                    ans.status      = ST_OK;
                    ans.found_value = slot_value[slot];
                end
            end
            REQ_REMOVE: begin
                slot = probe_chain(rq.key, int'(rq.start), int'(rq.step), 1'b0);
                if (slot >= 0 && slot_mark[slot] == MARK_BUSY) begin
                    slot_mark[slot] = MARK_DELETED;
                    busy_total--;
                    deleted_total++;
                    ans.status = ST_OK;
                end
            end
            default: ;
        endcase
        ans.occupied_count  = COUNT_W'(busy_total);
        ans.tombstone_count = COUNT_W'(deleted_total);
        return ans;
    endfunction

    task automatic push_req(t_req kind, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                            logic [HASH_W-1:0] start, logic [HASH_W-1:0] step);
        t_request rq;
        rq.kind  = kind;
        rq.key   = key;
        rq.value = value;
        rq.start = start;
        rq.step  = step;
        requests_todo.push_back(rq);
    endtask

    // Mostly keys from a shared pool with fixed hashes clustered at the low
    // slots, so inserts, hits, removes and tombstone reuse chain up; the rest
    // is random keys with random hashes.
    task automatic queue_random(int count);
        t_request rq;
        int       pick;
        int       k;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            rq.kind  = (pick < 40) ? REQ_INSERT : (pick < 72) ? REQ_FIND :
                       (pick < 96) ? REQ_REMOVE : REQ_UNUSED;
            rq.value = $urandom;
            if ($urandom_range(9) == 0) begin
                rq.key   = $urandom;
                rq.start = HASH_W'($urandom_range(DEPTH - 1));
                rq.step  = HASH_W'($urandom_range(DEPTH - 1));
            end else begin
                k = $urandom_range(POOL - 1);
                rq.key   = pool_key[k];
                rq.start = pool_start[k];
                rq.step  = pool_step[k];
            end
            requests_todo.push_back(rq);
        end
    endtask

    task automatic write_load_limit(logic [LOAD_W-1:0] pct);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= pct;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        load_limit = pct;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (requests_todo.size() != 0 || req_bus.valid || answers_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // request driver; the prediction is made when a transaction is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                answers_due.push_back(hash_table_apply(on_bus));
            if (!req_bus.valid || req_bus.ready) begin
                if (requests_todo.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
                    on_bus = requests_todo.pop_front();
                    req_bus.valid       <= 1'b1;
                    req_bus.req_type    <= on_bus.kind;
                    req_bus.req_key     <= on_bus.key;
                    req_bus.req_value   <= on_bus.value;
                    req_bus.probe_start <= on_bus.start;
                    req_bus.probe_step  <= on_bus.step;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response ready, with one long hold-off so the engine backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (!hold_done && results_seen >= 64) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= quiet || $urandom_range(99) >= 7;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                $error("response with nothing outstanding, status %0d", rsp_bus.status);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.found_value !== want.found_value) begin
                    $error("found_value: expected %h, got %h",
                           want.found_value, rsp_bus.found_value);
                    errors++;
                end
                if (rsp_bus.occupied_count !== want.occupied_count) begin
                    $error("occupied_count: expected %0d, got %0d",
                           want.occupied_count, rsp_bus.occupied_count);
                    errors++;
                end
                if (rsp_bus.tombstone_count !== want.tombstone_count) begin
                    $error("tombstone_count: expected %0d, got %0d",
                           want.tombstone_count, rsp_bus.tombstone_count);
                    errors++;
                end
            end
        end
    end

    // the run fails if the cycle counter reaches LIMIT
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_INSERT;
        req_bus.req_key     = '0;
        req_bus.req_value   = '0;
        req_bus.probe_start = '0;
        req_bus.probe_step  = '0;
        rsp_bus.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // above 100: load never refuses
        write_load_limit(7'd127);

        push_req(REQ_INSERT, 32'h0, 32'h0, 10'd0, 10'd0);
        push_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
        push_req(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 10'd1023, 10'd1023);
        push_req(REQ_INSERT, 32'h0, 32'h5, 10'd0, 10'd0);            // duplicate
        push_req(REQ_FIND, 32'h0, 32'hFFFF_FFFF, 10'd0, 10'd0);      // value unchanged
        push_req(REQ_INSERT, 32'h1, 32'h11, 10'd0, 10'd0);           // stride 0, no slot
        push_req(REQ_INSERT, 32'h2, 32'h22, 10'd0, 10'd512);
        push_req(REQ_FIND, 32'h3, 32'h0, 10'd0, 10'd512);            // two-slot orbit, miss
        push_req(REQ_REMOVE, 32'h7, 32'h0, 10'd5, 10'd1);            // remove miss
        push_req(REQ_REMOVE, 32'h0, 32'h0, 10'd0, 10'd0);
        push_req(REQ_FIND, 32'h0, 32'h0, 10'd0, 10'd0);              // only a tombstone
        push_req(REQ_INSERT, 32'h9, 32'h99, 10'd0, 10'd512);         // reuses slot 0
        push_req(REQ_REMOVE, 32'h2, 32'h0, 10'd0, 10'd512);
        push_req(REQ_INSERT, 32'h2, 32'hA, 10'd0, 10'd512);          // reuse, no empty seen
        push_req(REQ_INSERT, 32'd20, 32'h2020, 10'd100, 10'd3);
        push_req(REQ_INSERT, 32'd21, 32'h2121, 10'd100, 10'd3);
        push_req(REQ_REMOVE, 32'd20, 32'h0, 10'd100, 10'd3);
        push_req(REQ_FIND, 32'd21, 32'h0, 10'd100, 10'd3);           // past a tombstone
        push_req(REQ_INSERT, 32'd21, 32'h7777, 10'd100, 10'd3);      // dup beyond tombstone
        push_req(REQ_INSERT, 32'd22, 32'h2222, 10'd100, 10'd3);
        push_req(REQ_FIND, 32'd22, 32'h0, 10'd100, 10'd3);
        push_req(REQ_UNUSED, 32'd21, 32'h1234, 10'd100, 10'd3);
        push_req(REQ_FIND, 32'hDEAD_BEEF, 32'h0, 10'd777, 10'd0);    // stride 0 on empty
        wait_idle();

        for (int k = 0; k < POOL; k++) begin
            pool_key[k]   = $urandom;
            pool_start[k] = (k % 8 == 7) ? HASH_W'($urandom_range(DEPTH - 1))
                                         : HASH_W'($urandom_range(31));
            pool_step[k]  = HASH_W'($urandom_range(511) * 2 + 1);
        end
        // a few degenerate strides
        pool_step[0] = 10'd0;
        pool_step[1] = 10'd512;
        pool_step[2] = 10'd256;

        // no random idling on either side through this phase, but for the one long response hold-off
        write_load_limit(7'd100);
        quiet = 1'b1;
        queue_random(150);
        wait_idle();
        quiet = 1'b0;

        write_load_limit(7'd5);
        queue_random(120);
        wait_idle();

        write_load_limit(7'd0);
        queue_random(60);
        wait_idle();

        write_load_limit(7'd50);
        queue_random(170);
        wait_idle();

        repeat (16) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d responses never arrived", answers_due.size());
            errors++;
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
